// ----- sv/fem_pkg.sv -----
// fem_pkg: shared types and constants for the file extent map
// action and status codes, sequencer states, result item struct
// no dependencies

package fem_pkg;

  localparam int DW = 32;
  localparam int MAX_EXTENTS_DEF = 32;

  typedef enum logic [1:0] {
    ACT_CLEAR     = 2'd0,
    ACT_APPEND    = 2'd1,
    ACT_TRANSLATE = 2'd2,
    ACT_TRUNCATE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_APP_NEW,
    S_APP_MERGE,
    S_FOUND1,
    S_FOUND2,
    S_TR_NEXT,
    S_TR_LOAD,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [DW-1:0] physical_block;
    logic [DW-1:0] freed_start;
    logic [DW-1:0] freed_count;
    logic          last;
  } res_t;

endpackage

// ----- sv/file_extent_map.sv -----
// file_extent_map: ordered extent list of one file with clear, append,
// translate and truncate; top level with the result output register
// depends on fem_pkg, fem_ctrl
//
// usage:
//   input channel in_valid/in_ready carries action, position, run_length.
//   output channel out_valid/out_ready carries status, physical_block,
//   freed_start, freed_count and last; last marks the final item of an input.
//   clear, append and translate give one result item, truncate gives one per
//   freed range (or one with the out of range status).
//   one input item is worked on at a time; in_ready is high only when idle.
//   the sequencer reads one extent row per cycle through a single read port
//   and one shared adder. clear, a full table and a zero-length append go
//   straight to the result register; append scans the rows for one to merge
//   into, else writes a new row; translate and truncate scan to the row hit
//   or report out of range, and truncate then loads each further row as a range.
//   the next item is taken after its last result is registered; the
//   sequencer holds the next result until the output register frees.
//   reset empties the table; row contents are not cleared and need no pass.

module file_extent_map #(
  parameter int MAX_EXTENTS = fem_pkg::MAX_EXTENTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             action,
  input  logic [fem_pkg::DW-1:0] position,
  input  logic [fem_pkg::DW-1:0] run_length,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic [fem_pkg::DW-1:0] physical_block,
  output logic [fem_pkg::DW-1:0] freed_start,
  output logic [fem_pkg::DW-1:0] freed_count,
  output logic                   last
);

  fem_pkg::res_t res, res_q;
  logic          push, space;

  assign space = !out_valid || out_ready;

  fem_ctrl #(.MAX_EXTENTS(MAX_EXTENTS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .position   (position),
    .run_length (run_length),
    .space      (space),
    .push       (push),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) res_q <= res;
  end

  assign status         = res_q.status;
  assign physical_block = res_q.physical_block;
  assign freed_start    = res_q.freed_start;
  assign freed_count    = res_q.freed_count;
  assign last           = res_q.last;

endmodule

// ----- sv/fem_rows.sv -----
// fem_rows: extent row storage, start and length per row
// one write port, one read port with registered read data
// depends on fem_pkg

module fem_rows #(
  parameter int MAX_EXTENTS = fem_pkg::MAX_EXTENTS_DEF,
  parameter int AW = $clog2(MAX_EXTENTS)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [fem_pkg::DW-1:0] wr_start,
  input  logic [fem_pkg::DW-1:0] wr_len,
  input  logic [AW-1:0]          rd_addr,
  output logic [fem_pkg::DW-1:0] rd_start,
  output logic [fem_pkg::DW-1:0] rd_len
);

  logic [fem_pkg::DW-1:0] start_mem [MAX_EXTENTS];
  logic [fem_pkg::DW-1:0] len_mem   [MAX_EXTENTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_addr] <= wr_start;
      len_mem[wr_addr]   <= wr_len;
    end
  end

  always_ff @(posedge clk) begin
    rd_start <= start_mem[rd_addr];
    rd_len   <= len_mem[rd_addr];
  end

endmodule

// ----- sv/fem_addsub.sv -----
// fem_addsub: shared 33-bit adder/subtractor of the sequencer
// bit 32 is the carry on add and the borrow (a < b) on subtract
// depends on fem_pkg

module fem_addsub (
  input  logic [fem_pkg::DW-1:0] a,
  input  logic [fem_pkg::DW-1:0] b,
  input  logic                   sub,
  output logic [fem_pkg::DW:0]   sum
);

  logic [fem_pkg::DW:0] opb;

  assign opb = sub ? ~{1'b0, b} : {1'b0, b};
  assign sum = {1'b0, a} + opb + {{fem_pkg::DW{1'b0}}, sub};

endmodule

// ----- sv/fem_ctrl.sv -----
// fem_ctrl: sequencer that walks the extent rows one per cycle
// drives the row memory and the shared adder, builds result items
// depends on fem_pkg, fem_rows, fem_addsub

module fem_ctrl #(
  parameter int MAX_EXTENTS = fem_pkg::MAX_EXTENTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             action,
  input  logic [fem_pkg::DW-1:0] position,
  input  logic [fem_pkg::DW-1:0] run_length,
  input  logic                   space,
  output logic                   push,
  output fem_pkg::res_t          res
);

  localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int DW = fem_pkg::DW;

  fem_pkg::state_t  state, state_next;
  fem_pkg::action_t op;
  logic [DW-1:0]    pos_r, len_r, idx, start_row, len_row;
  logic [CW-1:0]    bound, row, rows_used;

  logic [AW-1:0]    rd_addr, wr_addr;
  logic             wr_en;
  logic [DW-1:0]    wr_start, wr_len, rd_start, rd_len;
  logic [DW-1:0]    alu_a, alu_b;
  logic             alu_sub;
  logic [DW:0]      alu_sum;

  logic             at_end, end_hit, fits, borrow, is_last_row;
  logic             is_append, is_full;
  fem_pkg::action_t in_act;

  assign in_act      = fem_pkg::action_t'(action);
  assign at_end      = (row == bound);
  assign end_hit     = (alu_sum == {1'b0, pos_r});
  assign fits        = (rd_len <= ~len_r);
  assign borrow      = alu_sum[DW];
  assign is_last_row = ((row + CW'(1)) == bound);
  assign is_append   = (op == fem_pkg::ACT_APPEND);
  assign is_full     = (rows_used >= CW'(MAX_EXTENTS));

  fem_rows #(.MAX_EXTENTS(MAX_EXTENTS), .AW(AW)) u_rows (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_start (wr_start),
    .wr_len   (wr_len),
    .rd_addr  (rd_addr),
    .rd_start (rd_start),
    .rd_len   (rd_len)
  );

  fem_addsub u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fem_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_act)
            fem_pkg::ACT_CLEAR: state_next = fem_pkg::S_PUSH;
            fem_pkg::ACT_APPEND: begin
              if (is_full || run_length == '0) state_next = fem_pkg::S_PUSH;
              else state_next = fem_pkg::S_SCAN;
            end
            default: state_next = fem_pkg::S_SCAN;
          endcase
        end
      end
      fem_pkg::S_SCAN: begin
        if (at_end) begin
          state_next = is_append ? fem_pkg::S_APP_NEW : fem_pkg::S_PUSH;
        end else if (is_append) begin
          if (end_hit && fits) state_next = fem_pkg::S_APP_MERGE;
        end else if (borrow) begin
          state_next = fem_pkg::S_FOUND1;
        end
      end
      fem_pkg::S_APP_NEW:   state_next = fem_pkg::S_PUSH;
      fem_pkg::S_APP_MERGE: state_next = fem_pkg::S_PUSH;
      fem_pkg::S_FOUND1: begin
        if (op == fem_pkg::ACT_TRANSLATE) state_next = fem_pkg::S_PUSH;
        else state_next = fem_pkg::S_FOUND2;
      end
      fem_pkg::S_FOUND2:  state_next = fem_pkg::S_PUSH;
      fem_pkg::S_TR_NEXT: state_next = fem_pkg::S_TR_LOAD;
      fem_pkg::S_TR_LOAD: state_next = fem_pkg::S_PUSH;
      fem_pkg::S_PUSH: begin
        if (space) state_next = res.last ? fem_pkg::S_IDLE : fem_pkg::S_TR_NEXT;
      end
      default: state_next = fem_pkg::S_IDLE;
    endcase
  end

  // outputs, memory and adder control
  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    rd_addr  = row[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = row[AW-1:0];
    wr_start = start_row;
    wr_len   = len_row;
    alu_a    = rd_start;
    alu_b    = rd_len;
    alu_sub  = 1'b0;
    case (state)
      fem_pkg::S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = '0;
      end
      fem_pkg::S_SCAN: begin
        rd_addr = AW'(row + CW'(1));
        if (!is_append) begin
          alu_a   = idx;
          alu_sub = 1'b1;
        end
      end
      fem_pkg::S_APP_NEW: begin
        wr_en    = 1'b1;
        wr_addr  = bound[AW-1:0];
        wr_start = pos_r;
        wr_len   = len_r;
      end
      fem_pkg::S_APP_MERGE: begin
        alu_a  = len_row;
        alu_b  = len_r;
        wr_en  = 1'b1;
        wr_len = alu_sum[DW-1:0];
      end
      fem_pkg::S_FOUND1: begin
        alu_a = start_row;
        alu_b = idx;
      end
      fem_pkg::S_FOUND2: begin
        alu_a   = len_row;
        alu_b   = idx;
        alu_sub = 1'b1;
        wr_en   = (idx != '0);
        wr_len  = idx;
      end
      fem_pkg::S_PUSH: push = space;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fem_pkg::S_IDLE;
      rows_used <= '0;
      row       <= '0;
    end else begin
      state <= state_next;
      case (state)
        fem_pkg::S_IDLE: begin
          if (in_valid) begin
            op                 <= in_act;
            pos_r              <= position;
            len_r              <= run_length;
            idx                <= position;
            bound              <= rows_used;
            row                <= '0;
            res.status         <= (in_act == fem_pkg::ACT_APPEND && is_full) ?
                                  fem_pkg::ST_FULL : fem_pkg::ST_OK;
            res.physical_block <= '0;
            res.freed_start    <= '0;
            res.freed_count    <= '0;
            res.last           <= 1'b1;
            if (in_act == fem_pkg::ACT_CLEAR) rows_used <= '0;
          end
        end
        fem_pkg::S_SCAN: begin
          if (at_end) begin
            if (!is_append) res.status <= fem_pkg::ST_RANGE;
          end else if (is_append) begin
            start_row <= rd_start;
            len_row   <= rd_len;
            if (!(end_hit && fits)) row <= row + CW'(1);
          end else begin
            start_row <= rd_start;
            len_row   <= rd_len;
            if (!borrow) begin
              idx <= alu_sum[DW-1:0];
              row <= row + CW'(1);
            end
          end
        end
        fem_pkg::S_APP_NEW: rows_used <= bound + CW'(1);
        fem_pkg::S_FOUND1: begin
          if (op == fem_pkg::ACT_TRANSLATE) begin
            res.physical_block <= alu_sum[DW-1:0];
          end else begin
            res.freed_start <= alu_sum[DW-1:0];
          end
        end
        fem_pkg::S_FOUND2: begin
          res.freed_count <= alu_sum[DW-1:0];
          res.last        <= is_last_row;
          rows_used       <= (idx == '0) ? row : row + CW'(1);
          row             <= row + CW'(1);
        end
        fem_pkg::S_TR_LOAD: begin
          res.freed_start <= rd_start;
          res.freed_count <= rd_len;
          res.last        <= is_last_row;
          row             <= row + CW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- verif/file_extent_map_checker.sv -----
// file_extent_map_checker: watches both channels of file_extent_map, keeps its own
// copy of the extent table, predicts every result item and compares it field by field
// depends on fem_pkg
`timescale 1ns / 1ps

module file_extent_map_checker #(
  parameter int MAX_EXTENTS = fem_pkg::MAX_EXTENTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [1:0]             action,
  input  logic [fem_pkg::DW-1:0] position,
  input  logic [fem_pkg::DW-1:0] run_length,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [1:0]             status,
  input  logic [fem_pkg::DW-1:0] physical_block,
  input  logic [fem_pkg::DW-1:0] freed_start,
  input  logic [fem_pkg::DW-1:0] freed_count,
  input  logic                   last,
  output int                     errors,
  output int                     pending,
  output int                     checked
);

  localparam int DW = fem_pkg::DW;

  logic [DW-1:0] extent_base [MAX_EXTENTS];
  logic [DW-1:0] extent_blocks [MAX_EXTENTS];
  int rows_held;
  fem_pkg::res_t replies[$];
  fem_pkg::res_t want;

  function automatic fem_pkg::res_t make_reply(fem_pkg::status_t st, logic [DW-1:0] phys,
                                               logic [DW-1:0] fs, logic [DW-1:0] fc,
                                               logic lst);
    fem_pkg::res_t r;
    r.status = st;
    r.physical_block = phys;
    r.freed_start = fs;
    r.freed_count = fc;
    r.last = lst;
    return r;
  endfunction

  task automatic apply_action(fem_pkg::action_t act, logic [DW-1:0] pos, logic [DW-1:0] len);
    int i;
    int row;
    bit found;
    bit merged;
    longint unsigned off;
    logic [DW:0] ext_end;
    logic [DW:0] sum;
    case (act)
      fem_pkg::ACT_CLEAR: begin
        rows_held = 0;
        replies.push_back(make_reply(fem_pkg::ST_OK, '0, '0, '0, 1'b1));
      end
      fem_pkg::ACT_APPEND: begin
        if (rows_held >= MAX_EXTENTS) begin
          replies.push_back(make_reply(fem_pkg::ST_FULL, '0, '0, '0, 1'b1));
        end else begin
          if (len != 0) begin
            merged = 0;
            for (i = 0; i < rows_held && !merged; i++) begin
              ext_end = {1'b0, extent_base[i]} + {1'b0, extent_blocks[i]};
              sum = {1'b0, extent_blocks[i]} + {1'b0, len};
              if (ext_end == {1'b0, pos} && !sum[DW]) begin
                extent_blocks[i] = sum[DW-1:0];
                merged = 1;
              end
            end
            if (!merged) begin
              extent_base[rows_held] = pos;
              extent_blocks[rows_held] = len;
              rows_held++;
            end
          end
          replies.push_back(make_reply(fem_pkg::ST_OK, '0, '0, '0, 1'b1));
        end
      end
      default: begin
        // walk the rows to the one holding the file block
        off = pos;
        found = 0;
        row = 0;
        for (i = 0; i < rows_held && !found; i++) begin
          if (off < extent_blocks[i]) begin
            found = 1;
            row = i;
          end else begin
            off -= extent_blocks[i];
          end
        end
        if (!found) begin
          replies.push_back(make_reply(fem_pkg::ST_RANGE, '0, '0, '0, 1'b1));
        end else if (act == fem_pkg::ACT_TRANSLATE) begin
          replies.push_back(make_reply(fem_pkg::ST_OK, extent_base[row] + off[DW-1:0],
                                       '0, '0, 1'b1));
        end else begin
          replies.push_back(make_reply(fem_pkg::ST_OK, '0, extent_base[row] + off[DW-1:0],
                                       extent_blocks[row] - off[DW-1:0],
                                       row == rows_held - 1));
          for (i = row + 1; i < rows_held; i++)
            replies.push_back(make_reply(fem_pkg::ST_OK, '0, extent_base[i],
                                         extent_blocks[i], i == rows_held - 1));
          if (off == 0) begin
            rows_held = row;
          end else begin
            extent_blocks[row] = off[DW-1:0];
            rows_held = row + 1;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_held = 0;
      replies.delete();
    end else begin
      if (in_valid && in_ready)
        apply_action(fem_pkg::action_t'(action), position, run_length);
      if (out_valid && out_ready) begin
        if (replies.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result item: status %0d phys %h fstart %h fcount %h last %b",
                     status, physical_block, freed_start, freed_count, last);
        end else begin
          want = replies.pop_front();
          checked++;
          if (status !== want.status || physical_block !== want.physical_block ||
              freed_start !== want.freed_start || freed_count !== want.freed_count ||
              last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t: expected status %0d phys %h fstart %h fcount %h last %b",
                       $realtime, want.status, want.physical_block, want.freed_start,
                       want.freed_count, want.last);
              $display("                 actual status %0d phys %h fstart %h fcount %h last %b",
                       status, physical_block, freed_start, freed_count, last);
            end
          end
        end
      end
    end
    pending = replies.size();
  end

endmodule

// ----- verif/file_extent_map_tb.sv -----
// file_extent_map_tb: clock, reset and stimulus for file_extent_map, with random
// sender gaps and receiver stalls; file_extent_map_checker does the comparing
// depends on fem_pkg, file_extent_map, file_extent_map_checker
`timescale 1ns / 1ps

module file_extent_map_tb;

  localparam int DW = fem_pkg::DW;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 96;

  logic          clk;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [1:0]    action = fem_pkg::ACT_CLEAR;
  logic [DW-1:0] position = '0;
  logic [DW-1:0] run_length = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [1:0]    status;
  logic [DW-1:0] physical_block;
  logic [DW-1:0] freed_start;
  logic [DW-1:0] freed_count;
  logic          last;

  int errors;
  int pending;
  int checked;
  int idle_pct;
  int stall_pct;
  int hold_seq;
  int hold_seen;
  int hold_left;
  int items_sent;
  int action_count [4];
  longint unsigned file_blocks;
  int rows_added;
  logic [DW-1:0] tail_end;

  file_extent_map dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .position(position), .run_length(run_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .physical_block(physical_block),
    .freed_start(freed_start), .freed_count(freed_count), .last(last)
  );

  file_extent_map_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .position(position), .run_length(run_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .physical_block(physical_block),
    .freed_start(freed_start), .freed_count(freed_count), .last(last),
    .errors(errors), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send(fem_pkg::action_t act, logic [DW-1:0] pos, logic [DW-1:0] len);
    bit took;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    position <= pos;
    run_length <= len;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    items_sent++;
    action_count[int'(act)]++;
    // rough picture of the file length and tail, only used to aim indices and starts
    case (act)
      fem_pkg::ACT_CLEAR: begin
        file_blocks = 0;
        rows_added = 0;
      end
      fem_pkg::ACT_APPEND: begin
        if (rows_added < fem_pkg::MAX_EXTENTS_DEF && len != 0) begin
          file_blocks += len;
          rows_added++;
          tail_end = pos + len;
        end
      end
      fem_pkg::ACT_TRUNCATE: begin
        if (pos < file_blocks)
          file_blocks = pos;
      end
      default: ;
    endcase
  endtask

  function automatic logic [DW-1:0] pick_index();
    longint unsigned bound;
    int r;
    r = $urandom_range(9);
    bound = (file_blocks > 64'hFFFF_FFFF) ? 64'h1_0000_0000 : file_blocks;
    if (bound == 0 || r == 0) begin
      if (file_blocks + 3 > 64'hFFFF_FFFF)
        return $urandom;
      return DW'(file_blocks + $urandom_range(3));
    end
    if (r == 1)
      return DW'(bound - 64'd1);
    return DW'({$urandom, $urandom} % bound);
  endfunction

  function automatic logic [DW-1:0] pick_length();
    int r;
    r = $urandom_range(19);
    if (r == 0)
      return $urandom;
    if (r == 1)
      return 32'hFFFF_FFFF - $urandom_range(255);
    return $urandom_range(64, 1);
  endfunction

  function automatic logic [DW-1:0] pick_start();
    int r;
    r = $urandom_range(9);
    if (r < 4)
      return tail_end;
    if (r == 4)
      return 32'hFFFF_FFFF - $urandom_range(31);
    return $urandom;
  endfunction

  task automatic fill_table();
    int k;
    send(fem_pkg::ACT_CLEAR, $urandom, $urandom);
    for (k = 0; k < fem_pkg::MAX_EXTENTS_DEF; k++)
      send(fem_pkg::ACT_APPEND, $urandom, $urandom_range(100, 1));
    send(fem_pkg::ACT_APPEND, tail_end, pick_length());
    send(fem_pkg::ACT_APPEND, $urandom, $urandom);
  endtask

  task automatic file_session();
    int k;
    int n;
    if ($urandom_range(3) == 0)
      send(fem_pkg::ACT_CLEAR, $urandom, $urandom);
    n = $urandom_range(8, 1);
    for (k = 0; k < n; k++)
      send(fem_pkg::ACT_APPEND, pick_start(), pick_length());
    n = $urandom_range(6, 2);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(9) < 6)
        send(fem_pkg::ACT_TRANSLATE, pick_index(), $urandom);
      else
        send(fem_pkg::ACT_TRUNCATE, pick_index(), $urandom);
    end
  endtask

  initial begin
    int base;
    int k;
    int kind;
    idle_pct = 32;
    stall_pct = 32;
    hold_seq = 0;
    file_blocks = 0;
    rows_added = 0;
    tail_end = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty table, zero-length append, address wrap, merge rules, row boundary cuts
    send(fem_pkg::ACT_TRANSLATE, 32'h0, 32'h0);
    send(fem_pkg::ACT_TRUNCATE, 32'h0, 32'h0);
    send(fem_pkg::ACT_APPEND, 32'h40, 32'h0);
    send(fem_pkg::ACT_TRANSLATE, 32'h0, 32'hFFFF_FFFF);
    send(fem_pkg::ACT_APPEND, 32'hFFFF_FFF0, 32'h20);
    send(fem_pkg::ACT_APPEND, 32'h10, 32'h5);
    send(fem_pkg::ACT_APPEND, 32'h15, 32'h3);
    send(fem_pkg::ACT_TRANSLATE, 32'h18, 32'h0);
    send(fem_pkg::ACT_TRANSLATE, 32'h27, 32'h0);
    send(fem_pkg::ACT_TRANSLATE, 32'h28, 32'h0);
    send(fem_pkg::ACT_TRANSLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(fem_pkg::ACT_TRUNCATE, 32'h20, 32'h0);
    send(fem_pkg::ACT_TRUNCATE, 32'h1C, 32'h0);
    send(fem_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(fem_pkg::ACT_APPEND, 32'h10, 32'hFFFF_FF00);
    send(fem_pkg::ACT_APPEND, 32'hFFFF_FF10, 32'h200);
    send(fem_pkg::ACT_APPEND, 32'hFFFF_FF10, 32'hFF);
    send(fem_pkg::ACT_APPEND, 32'h0, 32'hFFFF_FFFF);
    send(fem_pkg::ACT_TRANSLATE, 32'hFFFF_FFFF, 32'h0);
    send(fem_pkg::ACT_TRUNCATE, 32'hFFFF_FFFE, 32'h0);
    send(fem_pkg::ACT_TRUNCATE, 32'h0, 32'h0);
    send(fem_pkg::ACT_CLEAR, 32'h0, 32'h0);

    // full table cut at block zero; the receiver holds off while the table fills
    base = items_sent;
    idle_pct = 0;
    stall_pct = 0;
    hold_seq++;
    fill_table();
    send(fem_pkg::ACT_TRUNCATE, 32'h0, 32'h0);

    while (items_sent - base < RANDOM_ITEMS) begin
      case ((items_sent - base) * 4 / RANDOM_ITEMS)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      kind = $urandom_range(11);
      if (kind == 0) begin
        for (k = 0; k < 3; k++)
          send(fem_pkg::action_t'($urandom_range(3)), $urandom, $urandom);
      end else if (kind == 1) begin
        fill_table();
        send(fem_pkg::ACT_TRUNCATE, pick_index(), $urandom);
      end else begin
        file_session();
      end
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
    $display("sent %0d items: %0d clear, %0d append, %0d translate, %0d truncate",
             items_sent, action_count[0], action_count[1], action_count[2], action_count[3]);
    $display("checked %0d result items under gaps, stalls and a %0d-cycle hold-off",
             checked, HOLD_CYCLES);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
